FILE: hw/rtl/modal_to_actuator_matvec_unit_macros.svh
// assertion macros for the modal-to-actuator matvec unit
`ifndef MODAL_TO_ACTUATOR_MATVEC_UNIT_MACROS_SVH
`define MODAL_TO_ACTUATOR_MATVEC_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mam_pkg.sv
// shared types and constants of the modal-to-actuator matvec unit
`timescale 1ns / 1ps

package mam_pkg;

    localparam int MAX_ACTUATORS = 256;
    localparam int MAX_MODES     = 64;

    localparam int OP_W      = 2;
    localparam int MODE_W    = 6;
    localparam int ACT_W     = 8;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int CMD_W     = 40;
    localparam int NACT_W    = 9;
    localparam int NMODE_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int SHAPE_AW  = MODE_W + ACT_W;
    localparam int SHAPE_DEPTH = MAX_MODES * MAX_ACTUATORS;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE_SHAPE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_COEF  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ACTUATORS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_MODES     = 2'd1;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_FINISH
    } mam_state_t;

    // sequencer to datapath
    typedef struct packed {
        logic                   wr_shape;
        logic                   wr_coef;
        logic [MODE_W-1:0]      wr_mode;
        logic [ACT_W-1:0]       wr_act;
        logic signed [VAL_W-1:0] wr_value;
        logic                   clear;
        logic                   issue;
        logic [MODE_W-1:0]      rd_mode;
        logic [ACT_W-1:0]       rd_act;
    } mam_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic                    busy;
        logic signed [CMD_W-1:0] acc;
    } mam_stat_t;

endpackage

FILE: hw/rtl/mam_ifs.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface mam_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [mam_pkg::OP_W-1:0]              operation;
    logic [mam_pkg::MODE_W-1:0]            mode_number;
    logic [mam_pkg::ACT_W-1:0]             actuator_number;
    logic signed [mam_pkg::VAL_W-1:0]      write_value;

    modport source (output valid, operation, mode_number, actuator_number, write_value,
                    input ready);
    modport sink (input valid, operation, mode_number, actuator_number, write_value,
                  output ready);
endinterface

interface mam_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mam_pkg::CMD_W-1:0]      actuator_command;
    logic [mam_pkg::ACT_W-1:0]             actuator_echo;
    logic                                  status;

    modport source (output valid, actuator_command, actuator_echo, status, input ready);
    modport sink (input valid, actuator_command, actuator_echo, status, output ready);
endinterface

FILE: hw/rtl/modal_to_actuator_matvec_unit.sv
// top level of the modal-to-actuator matvec unit: sequencer, config and result register
`timescale 1ns / 1ps
`include "modal_to_actuator_matvec_unit_macros.svh"

// usage
// - req channel (valid/ready) takes one request: write a mode-shape entry, write a
//   mode coefficient, or compute one actuator command; operation 3 is dropped
// - rsp channel returns one result per compute request: the q2.30 command in 40 bits,
//   the actuator echo and a status bit (1 = actuator index out of range, command 0)
// - config port: cfg_we with cfg_index 0 = num_actuators, 1 = num_modes; others ignored
// - write requests are absorbed while idle; ready stays high
// - a compute request with n = min(num_modes, 64) modes streams one mode per cycle
//   through the shared multiply-accumulate unit: issue state, store read register,
//   product register and accumulator, then the result register is loaded; the result
//   turns valid at the same edge at which ready returns
// - an out-of-range index or zero modes skips the issue state (straight to the result load)
// - req ready is low from acceptance of a compute request until its result is loaded
// - the result register holds while rsp is stalled; writes are still accepted, and a
//   following compute waits with its sum in the accumulator until the register frees
// - reset clears the sequencer, the result valid flag, the config registers (256
//   actuators, 64 modes) and the coefficient store; the shape store is not cleared

module modal_to_actuator_matvec_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    mam_req_if.sink                         req,
    mam_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [mam_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mam_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import mam_pkg::*;

    // config registers
    logic [NACT_W-1:0]  num_act_reg;
    logic [NMODE_W-1:0] num_modes_reg;

    // sequencer
    mam_state_t         state_reg, state_next;
    logic [NMODE_W-1:0] mode_cnt_reg, mode_cnt_next;
    logic [NMODE_W-1:0] n_reg, n_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic               err_reg, err_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic signed [CMD_W-1:0] out_cmd_reg;
    logic [ACT_W-1:0]        out_echo_reg;
    logic                    out_status_reg;

    logic               req_acc;
    logic               is_compute;
    logic               act_bad;
    logic [NMODE_W-1:0] n_sat;
    logic [NMODE_W-1:0] cnt_inc;
    logic               out_free;
    logic               out_load;

    mam_ctrl_t ctrl;
    mam_stat_t dp_stat;

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_act_reg   <= NACT_W'(MAX_ACTUATORS);
            num_modes_reg <= NMODE_W'(MAX_MODES);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_ACTUATORS: num_act_reg   <= cfg_data[NACT_W-1:0];
                CFG_NUM_MODES:     num_modes_reg <= cfg_data[NMODE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign req_acc    = req.valid && req.ready;
    assign is_compute = (req.operation == OP_COMPUTE);

    // index check against both the configured count and the store size
    assign act_bad = ({1'b0, req.actuator_number} >= num_act_reg) ||
                     ({1'b0, req.actuator_number} >= NACT_W'(MAX_ACTUATORS));

    // mode count saturates at the store depth
    assign n_sat   = (num_modes_reg > NMODE_W'(MAX_MODES)) ? NMODE_W'(MAX_MODES)
                                                           : num_modes_reg;
    assign cnt_inc = mode_cnt_reg + NMODE_W'(1);

    assign out_free = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next    = state_reg;
        mode_cnt_next = mode_cnt_reg;
        n_next        = n_reg;
        act_next      = act_reg;
        err_next      = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc && is_compute)
                begin
                    act_next      = req.actuator_number;
                    err_next      = act_bad;
                    n_next        = n_sat;
                    mode_cnt_next = '0;
                    if (act_bad || (n_sat == '0))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                mode_cnt_next = cnt_inc;
                if (cnt_inc == n_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!dp_stat.busy && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer; ready is high in idle, so valid alone means accepted
    always_comb
    begin
        req.ready     = 1'b0;
        out_load      = 1'b0;
        ctrl.issue    = 1'b0;
        ctrl.clear    = 1'b0;
        ctrl.wr_shape = 1'b0;
        ctrl.wr_coef  = 1'b0;
        ctrl.wr_mode  = req.mode_number;
        ctrl.wr_act   = req.actuator_number;
        ctrl.wr_value = req.write_value;
        ctrl.rd_mode  = mode_cnt_reg[MODE_W-1:0];
        ctrl.rd_act   = act_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    ctrl.clear    = is_compute;
                    ctrl.wr_shape = (req.operation == OP_WRITE_SHAPE) &&
                                    ({1'b0, req.mode_number} < (MODE_W+1)'(MAX_MODES)) &&
                                    ({1'b0, req.actuator_number} < NACT_W'(MAX_ACTUATORS));
                    ctrl.wr_coef  = (req.operation == OP_WRITE_COEF) &&
                                    ({1'b0, req.mode_number} < (MODE_W+1)'(MAX_MODES));
                end
            end
            S_ISSUE:
            begin
                ctrl.issue = 1'b1;
            end
            S_FINISH:
            begin
                out_load = !dp_stat.busy && out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_cnt_reg <= '0;
            n_reg        <= '0;
            act_reg      <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_cnt_reg <= mode_cnt_next;
            n_reg        <= n_next;
            act_reg      <= act_next;
            err_reg      <= err_next;
        end
    end

    // shared multiply-accumulate over the stores
    mam_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (dp_stat)
    );

    // result register: holds while the receiver stalls
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // accumulator was cleared at acceptance, so a bad index loads zero
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cmd_reg    <= dp_stat.acc;
            out_echo_reg   <= act_reg;
            out_status_reg <= err_reg ? STATUS_BAD_INDEX : STATUS_OK;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.actuator_command = out_cmd_reg;
    assign rsp.actuator_echo    = out_echo_reg;
    assign rsp.status           = out_status_reg;

    // checks
    `MAM_ASSERT_IMP(a_err_zero,
        rsp.valid && (rsp.status == STATUS_BAD_INDEX), rsp.actuator_command == '0,
        "bad-index result carries nonzero command")
    `MAM_ASSERT_IMP(a_cnt_bound, state_reg == S_ISSUE, mode_cnt_reg < n_reg,
        "mode counter ran past mode count")
    `MAM_ASSERT_IMP(a_load_drained, out_load, !dp_stat.busy && out_free,
        "result loaded with mac pipeline busy or slot full")
    `MAM_ASSERT_NXT(a_compute_start,
        req_acc && is_compute && !act_bad && (n_sat != '0),
        (state_reg == S_ISSUE) && (mode_cnt_reg == '0),
        "compute request did not start issuing")

endmodule

FILE: hw/rtl/mam_datapath.sv
// coefficient and mode-shape stores with the shared multiply-accumulate unit
`timescale 1ns / 1ps

module mam_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  mam_pkg::mam_ctrl_t ctrl,
    output mam_pkg::mam_stat_t stat
);
    import mam_pkg::*;

    logic signed [VAL_W-1:0] coef_mem [MAX_MODES];
    logic signed [VAL_W-1:0] shape_mem [SHAPE_DEPTH];
    logic [MAX_MODES-1:0]    coef_vld_reg;

    logic signed [VAL_W-1:0] coef_rd_reg;
    logic                    coef_ok_reg;
    logic signed [VAL_W-1:0] shape_rd_reg;
    logic                    rd_vld_reg;

    logic signed [VAL_W-1:0]  coef_val;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [CMD_W-1:0]  acc_reg;
    logic signed [CMD_W-1:0]  acc_next;

    // shape row is mode, column is actuator: address = mode * MAX_ACTUATORS + actuator
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_shape)
        begin
            shape_mem[{ctrl.wr_mode, ctrl.wr_act}] <= ctrl.wr_value;
        end
        if (ctrl.issue)
        begin
            shape_rd_reg <= shape_mem[{ctrl.rd_mode, ctrl.rd_act}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_coef)
        begin
            coef_mem[ctrl.wr_mode] <= ctrl.wr_value;
        end
        if (ctrl.issue)
        begin
            coef_rd_reg <= coef_mem[ctrl.rd_mode];
        end
    end

    // valid bits stand in for the cleared coefficient store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            coef_ok_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_coef)
            begin
                coef_vld_reg[ctrl.wr_mode] <= 1'b1;
            end
            if (ctrl.issue)
            begin
                coef_ok_reg <= coef_vld_reg[ctrl.rd_mode];
            end
            rd_vld_reg   <= ctrl.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    assign coef_val  = coef_ok_reg ? coef_rd_reg : '0;
    assign prod_next = coef_val * shape_rd_reg;

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + CMD_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign stat.busy = rd_vld_reg | prod_vld_reg;
    assign stat.acc  = acc_reg;

endmodule
